// ----- sv/ehsp_pkg.sv -----
// Package for the escaped hex string parser.
// Holds the word types, the parser state type, character codes and decode helpers.
// Has no dependencies.
package ehsp_pkg;

	typedef struct packed {
		logic [7:0] char_in;
		logic       is_last;
		logic       strip_quotes;
	} in_word_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] byte_out;
		logic       done_res;
		logic       ok;
	} out_word_t;

	typedef enum logic [1:0] {
		PH_PLAIN  = 2'd0,
		PH_ESCAPE = 2'd1,
		PH_HEX    = 2'd2,
		PH_NIBBLE = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] pending_nibble;
		logic       at_start;
		logic       failed;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:          PH_PLAIN,
		pending_nibble: 4'h0,
		at_start:       1'b1,
		failed:         1'b0
	};

	localparam logic [7:0] CH_BAR       = 8'h7C;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;
	localparam logic [7:0] CASE_BIT     = 8'h20;
	localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

	function automatic logic is_hex_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c inside {8'h20, [8'h09:8'h0D]};
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] lower;
		logic [7:0] val;
		lower = c | CASE_BIT;
		if (c <= 8'h39) begin
			val = 8'(c - CH_ZERO);
		end else begin
			val = 8'(lower - CH_LOWER_A + HEX_ALPHA_BASE);
		end
		return val[3:0];
	endfunction

endpackage

// ----- sv/ehsp_in_reg.sv -----
// Input register stage of the escaped hex string parser.
// Holds one accepted character word until the parser consumes it; uses ehsp_pkg.
module ehsp_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  ehsp_pkg::in_word_t  req,
	input  logic                consume,
	output logic                valid_s1,
	output ehsp_pkg::in_word_t  word_s1
);

	assign req_stall = valid_s1 && !consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			word_s1 <= req;
		end
	end

endmodule

// ----- sv/ehsp_decode.sv -----
// Next-state and result logic of the escaped hex string parser.
// Purely combinational; uses the types and helpers of ehsp_pkg.
module ehsp_decode (
	input  ehsp_pkg::in_word_t  word,
	input  ehsp_pkg::state_t    state,
	output ehsp_pkg::state_t    next_state,
	output ehsp_pkg::out_word_t result,
	output logic                has_result
);

	logic       drop;
	logic       byte_valid;
	logic [7:0] byte_val;
	logic       hex_digit;
	logic       blank;
	logic [3:0] digit;
	ehsp_pkg::state_t nxt;

	assign drop      = word.strip_quotes && (state.at_start || word.is_last);
	assign hex_digit = ehsp_pkg::is_hex_digit(word.char_in);
	assign blank     = ehsp_pkg::is_blank(word.char_in);
	assign digit     = ehsp_pkg::hex_value(word.char_in);

	always_comb begin
		nxt          = state;
		nxt.at_start = 1'b0;
		byte_valid   = 1'b0;
		byte_val     = 8'h00;
		if (!drop && !state.failed) begin
			case (state.phase)
				ehsp_pkg::PH_PLAIN: begin
					if (word.char_in == ehsp_pkg::CH_BACKSLASH) begin
						nxt.phase = ehsp_pkg::PH_ESCAPE;
					end else if (word.char_in == ehsp_pkg::CH_BAR) begin
						nxt.phase = ehsp_pkg::PH_HEX;
					end else begin
						byte_valid = 1'b1;
						byte_val   = word.char_in;
					end
				end
				ehsp_pkg::PH_ESCAPE: begin
					byte_valid = 1'b1;
					byte_val   = word.char_in;
					nxt.phase  = ehsp_pkg::PH_PLAIN;
				end
				ehsp_pkg::PH_HEX: begin
					if (word.char_in == ehsp_pkg::CH_BAR) begin
						nxt.phase = ehsp_pkg::PH_PLAIN;
					end else if (hex_digit) begin
						nxt.pending_nibble = digit;
						nxt.phase          = ehsp_pkg::PH_NIBBLE;
					end else if (!blank) begin
						nxt.failed = 1'b1;
					end
				end
				ehsp_pkg::PH_NIBBLE: begin
					if (word.char_in == ehsp_pkg::CH_BAR) begin
						byte_valid = 1'b1;
						byte_val   = {4'h0, state.pending_nibble};
						nxt.phase  = ehsp_pkg::PH_PLAIN;
					end else if (hex_digit) begin
						byte_valid = 1'b1;
						byte_val   = {state.pending_nibble, digit};
						nxt.phase  = ehsp_pkg::PH_HEX;
					end else if (blank) begin
						byte_valid = 1'b1;
						byte_val   = {4'h0, state.pending_nibble};
						nxt.phase  = ehsp_pkg::PH_HEX;
					end else begin
						nxt.failed = 1'b1;
					end
				end
				default: begin
					nxt.phase = ehsp_pkg::PH_PLAIN;
				end
			endcase
		end

		result.byte_valid = byte_valid;
		result.byte_out   = byte_val;
		result.done_res   = word.is_last;
		result.ok         = word.is_last && !nxt.failed && (nxt.phase == ehsp_pkg::PH_PLAIN);

		if (word.is_last) begin
			next_state = ehsp_pkg::STATE_RESET;
		end else begin
			next_state = nxt;
		end
	end

	assign has_result = byte_valid || word.is_last;

endmodule

// ----- sv/ehsp_out_reg.sv -----
// Result register stage of the escaped hex string parser.
// Holds one result word until the receiver takes it; uses ehsp_pkg.
module ehsp_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  ehsp_pkg::out_word_t  result,
	output logic                 free,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output ehsp_pkg::out_word_t  rsp
);

	logic                valid_s2;
	ehsp_pkg::out_word_t word_s2;

	assign free      = !valid_s2 || !rsp_stall;
	assign rsp_valid = valid_s2;
	assign rsp       = word_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			word_s2 <= result;
		end
	end

endmodule

// ----- sv/escaped_hex_string_parser.sv -----
// Escaped hex string parser: one character word in, at most one result word out.
// Each character is registered in the input stage and its result word in the result stage.
// Throughput: one character per cycle unless a held result stalls; state updates in a single pass.
// Reset clears the parser to plain text at the start of a string and empties both stages.
// Depends on ehsp_pkg, ehsp_in_reg, ehsp_decode and ehsp_out_reg.
module escaped_hex_string_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  ehsp_pkg::in_word_t   req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output ehsp_pkg::out_word_t  rsp
);

	logic                valid_s1;
	ehsp_pkg::in_word_t  word_s1;
	ehsp_pkg::state_t    state_q;
	ehsp_pkg::state_t    next_state;
	ehsp_pkg::out_word_t result;
	logic                has_result;
	logic                free;
	logic                consume;
	logic                load;

	assign consume = valid_s1 && (!has_result || free);
	assign load    = valid_s1 && has_result;

	ehsp_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.consume   (consume),
		.valid_s1  (valid_s1),
		.word_s1   (word_s1)
	);

	ehsp_decode u_decode (
		.word       (word_s1),
		.state      (state_q),
		.next_state (next_state),
		.result     (result),
		.has_result (has_result)
	);

	ehsp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.result    (result),
		.free      (free),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ehsp_pkg::STATE_RESET;
		end else if (consume) begin
			state_q <= next_state;
		end
	end

`ifndef SYNTH
	a_last_resets_state: assert property (@(posedge clk) disable iff (!arst_n)
		consume && word_s1.is_last |=> state_q == ehsp_pkg::STATE_RESET)
		else $error("parser state not cleared after the last character");

	a_failed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		consume && !word_s1.is_last && state_q.failed |=> state_q.failed)
		else $error("error flag cleared inside a string");

	a_no_byte_after_fail: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && state_q.failed |-> !result.byte_valid)
		else $error("byte produced after an error");

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && has_result && !free)
		else $error("input stalled without a blocked result");
`endif

endmodule

// ----- test/testbench.sv -----
// Testbench for the escaped hex string parser: directed strings, random well-formed and noisy text.
// Predicts each result word from its own copy of the parser state and checks it against the DUT.
// Depends on ehsp_pkg and escaped_hex_string_parser.
`timescale 1ns / 100ps

module testbench;

	typedef logic [7:0] char_q_t[$];

	localparam int         CYCLE_LIMIT = 300000;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_F  = 8'h46;
	localparam logic [7:0] CH_LOWER_F  = 8'h66;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_SPACE    = 8'h20;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	ehsp_pkg::in_word_t  req = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	ehsp_pkg::out_word_t rsp;

	ehsp_pkg::phase_t cur_phase = ehsp_pkg::PH_PLAIN;
	logic [3:0]       held_nibble = 4'h0;
	logic             at_head = 1'b1;
	logic             hex_error = 1'b0;

	ehsp_pkg::out_word_t awaited_words[$];
	int        failures = 0;
	int        cycles = 0;
	int        sent_count = 0;
	int        stall_left = 0;
	bit        quiet = 1'b0;

	escaped_hex_string_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic hex_char(input logic [7:0] c);
		return (c >= ehsp_pkg::CH_ZERO && c <= CH_NINE) ||
			(c >= CH_UPPER_A && c <= CH_UPPER_F) ||
			(c >= ehsp_pkg::CH_LOWER_A && c <= CH_LOWER_F);
	endfunction

	function automatic logic blank_char(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [3:0] nibble_val(input logic [7:0] c);
		logic [7:0] v;
		if (c <= CH_NINE) begin
			v = c - ehsp_pkg::CH_ZERO;
		end else if (c >= ehsp_pkg::CH_LOWER_A) begin
			v = c - ehsp_pkg::CH_LOWER_A + 8'd10;
		end else begin
			v = c - CH_UPPER_A + 8'd10;
		end
		return v[3:0];
	endfunction

	function automatic bit decode_char(input ehsp_pkg::in_word_t w,
		output ehsp_pkg::out_word_t r);
		logic       first;
		logic       emit;
		logic [7:0] val;
		logic [7:0] c;
		c = w.char_in;
		first = at_head;
		emit = 1'b0;
		val = 8'h00;
		at_head = 1'b0;
		if (!(w.strip_quotes && (first || w.is_last)) && !hex_error) begin
			case (cur_phase)
				ehsp_pkg::PH_PLAIN: begin
					if (c == ehsp_pkg::CH_BACKSLASH) begin
						cur_phase = ehsp_pkg::PH_ESCAPE;
					end else if (c == ehsp_pkg::CH_BAR) begin
						cur_phase = ehsp_pkg::PH_HEX;
					end else begin
						emit = 1'b1;
						val = c;
					end
				end
				ehsp_pkg::PH_ESCAPE: begin
					emit = 1'b1;
					val = c;
					cur_phase = ehsp_pkg::PH_PLAIN;
				end
				ehsp_pkg::PH_HEX: begin
					if (c == ehsp_pkg::CH_BAR) begin
						cur_phase = ehsp_pkg::PH_PLAIN;
					end else if (hex_char(c)) begin
						held_nibble = nibble_val(c);
						cur_phase = ehsp_pkg::PH_NIBBLE;
					end else if (!blank_char(c)) begin
						hex_error = 1'b1;
					end
				end
				default: begin
					if (c == ehsp_pkg::CH_BAR) begin
						emit = 1'b1;
						val = {4'h0, held_nibble};
						cur_phase = ehsp_pkg::PH_PLAIN;
					end else if (hex_char(c)) begin
						emit = 1'b1;
						val = {held_nibble, nibble_val(c)};
						cur_phase = ehsp_pkg::PH_HEX;
					end else if (blank_char(c)) begin
						emit = 1'b1;
						val = {4'h0, held_nibble};
						cur_phase = ehsp_pkg::PH_HEX;
					end else begin
						hex_error = 1'b1;
					end
				end
			endcase
		end
		r.byte_valid = emit;
		r.byte_out = emit ? val : 8'h00;
		r.done_res = w.is_last;
		r.ok = w.is_last && !hex_error && cur_phase == ehsp_pkg::PH_PLAIN;
		if (w.is_last) begin
			cur_phase = ehsp_pkg::PH_PLAIN;
			held_nibble = 4'h0;
			at_head = 1'b1;
			hex_error = 1'b0;
		end
		return emit || w.is_last;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 20);
	endfunction

	task automatic send_char(input logic [7:0] c, input logic last, input logic strip);
		int                  gap;
		ehsp_pkg::in_word_t  w;
		ehsp_pkg::out_word_t r;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w.char_in = c;
		w.is_last = last;
		w.strip_quotes = strip;
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall);
		sent_count++;
		if (decode_char(w, r)) begin
			awaited_words.push_back(r);
		end
	endtask

	task automatic send_seq(input char_q_t chars, input bit strip);
		foreach (chars[i]) begin
			send_char(chars[i], i == chars.size() - 1, strip);
		end
	endtask

	function automatic logic [7:0] random_hex_char();
		case ($urandom_range(0, 2))
			0: return ehsp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
			1: return CH_UPPER_A + 8'($urandom_range(0, 5));
			default: return ehsp_pkg::CH_LOWER_A + 8'($urandom_range(0, 5));
		endcase
	endfunction

	function automatic logic [7:0] random_blank();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
	endfunction

	function automatic char_q_t make_text();
		char_q_t    s;
		logic [7:0] c;
		int         n;
		int         m;
		n = $urandom_range(1, 5);
		repeat (n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					c = 8'($urandom_range(0, 255));
					if (c == ehsp_pkg::CH_BAR || c == ehsp_pkg::CH_BACKSLASH) begin
						s.push_back(ehsp_pkg::CH_BACKSLASH);
					end
					s.push_back(c);
				end
				4: begin
					s.push_back(ehsp_pkg::CH_BACKSLASH);
					s.push_back(8'($urandom_range(0, 255)));
				end
				5, 6, 7, 8: begin
					s.push_back(ehsp_pkg::CH_BAR);
					m = $urandom_range(0, 4);
					repeat (m) begin
						repeat ($urandom_range(0, 2)) s.push_back(random_blank());
						s.push_back(random_hex_char());
						if ($urandom_range(0, 2) != 0) begin
							s.push_back(random_hex_char());
						end
						if ($urandom_range(0, 1) == 1) begin
							s.push_back(random_blank());
						end
					end
					s.push_back(ehsp_pkg::CH_BAR);
				end
				default: begin
					s.push_back(8'($urandom_range(0, 255)));
				end
			endcase
		end
		if ($urandom_range(0, 9) == 0 && s.size() > 1) begin
			void'(s.pop_back());
		end
		return s;
	endfunction

	task automatic report_mismatch(input string what, input ehsp_pkg::out_word_t want,
		input ehsp_pkg::out_word_t got);
		failures++;
		if (failures <= 10) begin
			$display("%0t: %s: expected valid=%0b byte=%02h done=%0b ok=%0b",
				$realtime, what, want.byte_valid, want.byte_out, want.done_res, want.ok);
			$display("%0t: %s: got valid=%0b byte=%02h done=%0b ok=%0b",
				$realtime, what, got.byte_valid, got.byte_out, got.done_res, got.ok);
		end
	endtask

	always @(posedge clk) begin
		ehsp_pkg::out_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_words.size() == 0) begin
				report_mismatch("unexpected word", '0, rsp);
			end else begin
				want = awaited_words.pop_front();
				if (rsp.byte_valid !== want.byte_valid || rsp.byte_out !== want.byte_out ||
					rsp.done_res !== want.done_res || rsp.ok !== want.ok) begin
					report_mismatch("word mismatch", want, rsp);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 99) < 20) begin
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(4, 24) :
				$urandom_range(0, 2);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic test_directed();
		send_seq('{8'h00, 8'hFF}, 1'b0);
		send_seq('{ehsp_pkg::CH_BACKSLASH, ehsp_pkg::CH_BAR, ehsp_pkg::CH_BAR, "A", "b",
			CH_SPACE, "7", ehsp_pkg::CH_BAR}, 1'b0);
		send_seq('{ehsp_pkg::CH_BAR, "f", CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR, "0",
			ehsp_pkg::CH_BAR}, 1'b0);
		send_seq('{ehsp_pkg::CH_BAR, 8'h80, "x"}, 1'b0);
		send_seq('{ehsp_pkg::CH_QUOTE, "a", ehsp_pkg::CH_QUOTE}, 1'b1);
		send_seq('{ehsp_pkg::CH_QUOTE}, 1'b1);
		send_seq('{ehsp_pkg::CH_BACKSLASH}, 1'b0);
	endtask

	task automatic test_well_formed(input int count);
		char_q_t s;
		bit      strip;
		int      stop_at;
		stop_at = sent_count + count;
		while (sent_count < stop_at) begin
			if ($urandom_range(0, 19) == 0) begin
				quiet = ~quiet;
			end
			s = make_text();
			strip = $urandom_range(0, 2) == 0;
			if (strip) begin
				s.push_front(ehsp_pkg::CH_QUOTE);
				s.push_back(ehsp_pkg::CH_QUOTE);
			end
			send_seq(s, strip);
		end
		quiet = 1'b0;
	endtask

	task automatic test_drain_pause();
		req_valid <= 1'b0;
		wait (awaited_words.size() == 0);
		send_seq('{ehsp_pkg::CH_BAR, "9", ehsp_pkg::CH_BAR}, 1'b0);
		req_valid <= 1'b0;
		wait (awaited_words.size() == 0);
	endtask

	task automatic test_noise(input int count);
		repeat (count) begin
			send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
				1'($urandom_range(0, 1)));
		end
		send_char(CH_SPACE, 1'b1, 1'b0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_well_formed(600);
		test_drain_pause();
		test_well_formed(550);
		test_noise(300);
		req_valid <= 1'b0;
		wait (awaited_words.size() == 0);
		repeat (8) @(posedge clk);
		if (failures == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/ehsp_pkg.sv
sv/ehsp_in_reg.sv
sv/ehsp_decode.sv
sv/ehsp_out_reg.sv
sv/escaped_hex_string_parser.sv
test/testbench.sv
